FILE: sv/kerp_pkg.sv
// Shared constants and types for the key edge event recorder and player.
`default_nettype none
package kerp_pkg;

  localparam int KEY_W         = 16;   // width of the key vectors on the ports
  localparam int KEY_LIM       = 32;   // key index space of an event word
  localparam int KEY_IDX_W     = 5;
  localparam int FRAME_W       = 16;
  localparam int POS_W         = 11;
  localparam int CFG_W         = 5;
  localparam int MAX_KEYS_DEF  = 16;
  localparam int LOG_DEPTH_DEF = 1024;

  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_START_REC  = 2'd1;
  localparam logic [1:0] CMD_START_PLAY = 2'd2;
  localparam logic [1:0] CMD_STOP       = 2'd3;

  localparam logic                 REG_KEYS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0]     KEYS_RESET      = 5'd16;
  localparam logic [KEY_IDX_W-1:0] END_KEY         = 5'd31;

  typedef struct packed {
    logic                 down;
    logic [KEY_IDX_W-1:0] key;
    logic [FRAME_W-1:0]   frame;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

endpackage
`default_nettype wire

FILE: sv/key_edge_event_recorder_player.sv
// Key edge event recorder and player: top level.
// Frame tick with n keys in use: recording visits one key per cycle;
// playing waits for RAM read data before the first key and after each
// replayed event. One beat is in process, a second may wait in the output
// register.
// rst_n (synchronous, active low) clears modes, pointers, counters and flags;
// the event RAM is not cleared and is only read below the recorded length.
`default_nettype none
module key_edge_event_recorder_player #(
  parameter int MAX_KEYS  = kerp_pkg::MAX_KEYS_DEF,
  parameter int LOG_DEPTH = kerp_pkg::LOG_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_command,
  input  wire logic [kerp_pkg::KEY_W-1:0]    in_key_bits,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [kerp_pkg::KEY_W-1:0]    out_held_bits,
  output logic      [kerp_pkg::KEY_W-1:0]    out_down_bits,
  output logic      [kerp_pkg::KEY_W-1:0]    out_up_bits,
  output logic                               out_any_held,
  output logic                               out_is_recording,
  output logic                               out_is_playing,
  output logic                               out_play_done,
  output logic      [kerp_pkg::FRAME_W-1:0]  out_frame_number,
  output logic      [kerp_pkg::POS_W-1:0]    out_event_position,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  localparam int KW = kerp_pkg::KEY_W;
  localparam int FW = kerp_pkg::FRAME_W;
  localparam int LW = kerp_pkg::KEY_LIM;
  localparam int IW = kerp_pkg::KEY_IDX_W;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int AW = $clog2(LOG_DEPTH);
  localparam int PW = $clog2(LOG_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(LOG_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REC  = 2'd1;
  localparam logic [1:0] ST_PLAY = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [kerp_pkg::CFG_W-1:0]  kiu_r;
  logic [KW-1:0]               held_mem_r, held_mem_nxt;
  logic [KW-1:0]               live_held_r, live_held_nxt;
  logic [KW-1:0]               live_down_r, live_down_nxt;
  logic [KW-1:0]               live_up_r, live_up_nxt;
  logic                        any_live_r, any_live_nxt;
  logic [KW-1:0]               rep_held_r, rep_held_nxt;
  logic [KW-1:0]               rep_down_r, rep_down_nxt;
  logic [PW-1:0]               ptr_r, ptr_nxt;
  logic [PW-1:0]               len_r, len_nxt;
  logic [FW-1:0]               frame_r, frame_nxt;
  logic                        rec_r, rec_nxt;
  logic                        play_r, play_nxt;
  logic                        done_r, done_nxt;
  logic                        stop_r, stop_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        rd_ok_r, rd_ok_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_load;

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  kerp_pkg::event_t            ram_wdata;
  logic [kerp_pkg::EVENT_W-1:0] ram_rdata_raw;
  kerp_pkg::event_t            ram_rdata;

  logic [CW:0]                 kc6;
  logic [CW-1:0]               kc;
  logic [KW-1:0]               mask;
  logic [KW-1:0]               now_bits, prev_bits;
  logic [LW-1:0]               held_x, down_x, bit_sel;
  logic [IW-1:0]               idx5;
  logic                        ptr_lt_d, ptr_lt_len, idx_end, cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == kerp_pkg::REG_KEYS_IN_USE) ? 32'(kiu_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kiu_r <= kerp_pkg::KEYS_RESET;
    end else if (cfg_wr && paddr[2] == kerp_pkg::REG_KEYS_IN_USE) begin
      kiu_r <= pwdata[kerp_pkg::CFG_W-1:0];
    end
  end

  // keys in use, clamped to MAX_KEYS, and the matching key mask
  always_comb begin
    kc6 = (32'(kiu_r) > 32'(MAX_KEYS)) ? (CW + 1)'(MAX_KEYS) : (CW + 1)'(kiu_r);
    kc = kc6[CW-1:0];
    for (int j = 0; j < KW; j++) begin
      mask[j] = (32'(j) < 32'(kc6));
    end
  end

  // ---------------- event store ----------------
  assign ram_addr  = ptr_r[AW-1:0];
  assign ram_rdata = kerp_pkg::event_t'(ram_rdata_raw);

  kerp_ram #(
    .WIDTH (kerp_pkg::EVENT_W),
    .DEPTH (LOG_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata_raw)
  );

  // ---------------- sequencer ----------------
  assign in_ready   = (state_r == ST_IDLE);
  assign now_bits   = in_key_bits & mask;
  assign prev_bits  = held_mem_r & mask;
  assign held_x     = LW'(live_held_r);
  assign down_x     = LW'(live_down_r);
  assign idx5       = IW'(idx_r);
  assign bit_sel    = LW'(1) << idx5;
  assign ptr_lt_d   = ptr_r < DEPTH_P;
  assign ptr_lt_len = ptr_r < len_r;
  assign idx_end    = (idx_r == kc);
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    held_mem_nxt  = held_mem_r;
    live_held_nxt = live_held_r;
    live_down_nxt = live_down_r;
    live_up_nxt   = live_up_r;
    any_live_nxt  = any_live_r;
    rep_held_nxt  = rep_held_r;
    rep_down_nxt  = rep_down_r;
    ptr_nxt       = ptr_r;
    len_nxt       = len_r;
    frame_nxt     = frame_r;
    rec_nxt       = rec_r;
    play_nxt      = play_r;
    done_nxt      = done_r;
    stop_nxt      = stop_r;
    idx_nxt       = idx_r;
    rd_ok_nxt     = rd_ok_r;
    ram_we        = 1'b0;
    ram_wdata     = '{down: 1'b0, key: kerp_pkg::END_KEY, frame: frame_r};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FIN;
          case (in_command)
            kerp_pkg::CMD_TICK: begin
              live_held_nxt = now_bits;
              live_down_nxt = now_bits & ~prev_bits;
              live_up_nxt   = prev_bits & ~now_bits;
              held_mem_nxt  = now_bits;
              any_live_nxt  = |now_bits;
              if (rec_r) begin
                if (ptr_lt_d && !stop_r) begin
                  idx_nxt   = '0;
                  state_nxt = ST_REC;
                end else begin
                  // recording ends: end marker if there is room
                  len_nxt = ptr_r;
                  if (ptr_lt_d) begin
                    ram_we  = 1'b1;
                    ptr_nxt = ptr_r + PW'(1);
                  end
                  rec_nxt  = 1'b0;
                  stop_nxt = 1'b0;
                end
              end else if (play_r) begin
                rep_held_nxt = '0;
                rep_down_nxt = '0;
                if (ptr_lt_d && ptr_lt_len && !stop_r) begin
                  idx_nxt   = '0;
                  rd_ok_nxt = 1'b0;
                  state_nxt = ST_PLAY;
                end else begin
                  play_nxt  = 1'b0;
                  stop_nxt  = 1'b0;
                  done_nxt  = 1'b1;
                  frame_nxt = '0;
                end
              end
            end
            kerp_pkg::CMD_START_REC: begin
              rec_nxt   = 1'b1;
              play_nxt  = 1'b0;
              done_nxt  = 1'b0;
              stop_nxt  = 1'b0;
              frame_nxt = '0;
              ptr_nxt   = '0;
              len_nxt   = '0;
            end
            kerp_pkg::CMD_START_PLAY: begin
              rec_nxt   = 1'b0;
              play_nxt  = 1'b1;
              done_nxt  = 1'b0;
              stop_nxt  = 1'b0;
              frame_nxt = '0;
              ptr_nxt   = '0;
            end
            default: begin
              stop_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_REC: begin
        if (idx_end) begin
          frame_nxt = frame_r + FW'(1);
          state_nxt = ST_FIN;
        end else begin
          if (held_x[idx5] && ptr_lt_d) begin
            ram_we    = 1'b1;
            ram_wdata = '{down: down_x[idx5], key: idx5, frame: frame_r};
            ptr_nxt   = ptr_r + PW'(1);
            len_nxt   = ptr_r + PW'(1);
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      ST_PLAY: begin
        if (idx_end || !ptr_lt_len || !ptr_lt_d) begin
          frame_nxt = frame_r + FW'(1);
          state_nxt = ST_FIN;
        end else if (!rd_ok_r) begin
          // read data for the new pointer lands next cycle
          rd_ok_nxt = 1'b1;
        end else begin
          if (ram_rdata.frame == frame_r && ram_rdata.key == idx5) begin
            rep_held_nxt = rep_held_r | bit_sel[KW-1:0];
            if (ram_rdata.down) begin
              rep_down_nxt = rep_down_r | bit_sel[KW-1:0];
            end
            ptr_nxt   = ptr_r + PW'(1);
            rd_ok_nxt = 1'b0;
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      default: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_mem_r  <= '0;
      live_held_r <= '0;
      live_down_r <= '0;
      live_up_r   <= '0;
      any_live_r  <= 1'b0;
      rep_held_r  <= '0;
      rep_down_r  <= '0;
      ptr_r       <= '0;
      len_r       <= '0;
      frame_r     <= '0;
      rec_r       <= 1'b0;
      play_r      <= 1'b0;
      done_r      <= 1'b0;
      stop_r      <= 1'b0;
      idx_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_mem_r  <= held_mem_nxt;
      live_held_r <= live_held_nxt;
      live_down_r <= live_down_nxt;
      live_up_r   <= live_up_nxt;
      any_live_r  <= any_live_nxt;
      rep_held_r  <= rep_held_nxt;
      rep_down_r  <= rep_down_nxt;
      ptr_r       <= ptr_nxt;
      len_r       <= len_nxt;
      frame_r     <= frame_nxt;
      rec_r       <= rec_nxt;
      play_r      <= play_nxt;
      done_r      <= done_nxt;
      stop_r      <= stop_nxt;
      idx_r       <= idx_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_held_bits      <= (play_r ? rep_held_r : live_held_r) & mask;
      out_down_bits      <= (play_r ? rep_down_r : live_down_r) & mask;
      out_up_bits        <= play_r ? '0 : (live_up_r & mask);
      out_any_held       <= any_live_r;
      out_is_recording   <= rec_r;
      out_is_playing     <= play_r;
      out_play_done      <= done_r;
      out_frame_number   <= frame_r;
      out_event_position <= kerp_pkg::POS_W'(ptr_r);
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_r && play_r))
    else $error("record and play modes both active");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= DEPTH_P)
    else $error("event pointer beyond store depth");

  a_play_in_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLAY) |-> (ptr_r <= len_r))
    else $error("playback pointer past recorded length");

  a_write_when: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (rec_r && (state_r == ST_REC || state_r == ST_IDLE)))
    else $error("event store written outside recording");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN))
    else $error("result dropped while output slot busy");

endmodule
`default_nettype wire

FILE: sv/kerp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module kerp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
